### sv/swdrm_pkg.sv
package swdrm_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 20;

  localparam logic [CFG_INDEX_W-1:0] CFG_UNIT_LEN = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ALPHA    = 1'd1;

  localparam logic [15:0] UNIT_LEN_RESET = 16'd6000;
  localparam logic [19:0] ALPHA_RESET    = 20'd53032;

  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;
  localparam logic [47:0] SAT48 = 48'hFFFF_FFFF_FFFF;
  localparam logic [25:0] SAT26 = 26'h3FF_FFFF;
  localparam logic [16:0] SAT17 = 17'h1_FFFF;

  // counts per minute and micro-sievert scale factors, in thousandths
  localparam logic [35:0] CPM_SCALE  = 36'd60000000;
  localparam logic [35:0] DOSE_SCALE = 36'd60000000000;

  localparam logic [5:0] SQRT_STEPS = 6'd32;
  localparam logic [5:0] DIV_STEPS  = 6'd48;

  typedef struct packed {
    logic [15:0] period_ms;
    logic [15:0] pulse_count;
    logic [15:0] noise_count;
  } item_t;

  typedef struct packed {
    logic [31:0] window_count;
    logic [25:0] integration_ms;
    logic [47:0] cpm_milli;
    logic [47:0] dose_rate_milli;
    logic [47:0] dose_error_milli;
    logic        noise_seen;
    logic        pulses_seen;
  } result_t;

endpackage

### sv/swdrm_ram.sv
module swdrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/sliding_window_dose_rate_meter.sv
// channel   direction  signals                          payload
// item      in         item_valid / item_stall          item_t (period, pulses, noise)
// result    out        result_valid / result_stall      result_t (sum, time, rates, flags)
// config    in         cfg_we / cfg_index / cfg_data    bin length, alpha
//
// an item passes from one accept to the next through accept, bin and time update, 32 square-root
// steps and three divisions, all on one shared 64-bit subtractor
// with an integration time of zero the rates are skipped
// after reset a clearing pass zeroes every bin of the bin ram, items stall meanwhile
// a finished result waits in the output register; the next item is taken meanwhile,
// but its result waits until the previous one has gone
module sliding_window_dose_rate_meter
  import swdrm_pkg::*;
#(
  parameter int BIN_COUNT = 256
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  output logic                   item_stall,
  input  item_t                  item,
  output logic                   result_valid,
  input  logic                   result_stall,
  output result_t                result,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SLOT_W = $clog2(BIN_COUNT);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(BIN_COUNT - 1);

  // sequencer states
  typedef enum logic [12:0] {
    S_CLR  = 13'b0_0000_0000_0001,
    S_IDLE = 13'b0_0000_0000_0010,
    S_ADD  = 13'b0_0000_0000_0100,
    S_DROP = 13'b0_0000_0000_1000,
    S_TIME = 13'b0_0000_0001_0000,
    S_TA   = 13'b0_0000_0010_0000,
    S_SQRT = 13'b0_0000_0100_0000,
    S_MLO  = 13'b0_0000_1000_0000,
    S_MHI  = 13'b0_0001_0000_0000,
    S_MSUM = 13'b0_0010_0000_0000,
    S_CHK  = 13'b0_0100_0000_0000,
    S_DIV  = 13'b0_1000_0000_0000,
    S_DONE = 13'b1_0000_0000_0000
  } state_t;

  // which rate the divider is working on
  typedef enum logic [1:0] {
    OP_CPM  = 2'd0,
    OP_DOSE = 2'd1,
    OP_ERR  = 2'd2
  } op_t;

  state_t state;
  op_t    op;

  // configuration
  logic [15:0] unit_len;
  logic [19:0] alpha;
  logic [15:0] unit_eff;
  logic [19:0] alpha_eff;

  // window state
  logic [SLOT_W-1:0] write_slot;
  logic [SLOT_W-1:0] slot_inc;
  logic [SLOT_W-1:0] filled_units;
  logic [SLOT_W-1:0] clr_cnt;
  logic [16:0]       time_in_unit;
  logic [31:0]       window_sum;

  // latched item
  item_t held;
  logic  advance;

  // arithmetic registers
  logic [25:0] t_reg;
  logic [45:0] ta_reg;
  logic [31:0] sq_src;
  logic [33:0] sq_rem;
  logic [31:0] sq_root;
  logic [49:0] mul_lo;
  logic [49:0] mul_hi;
  logic [67:0] num;
  logic [62:0] div_rem;
  logic [47:0] quo;
  logic [5:0]  cnt;
  logic [47:0] cpm_q;
  logic [47:0] dose_q;
  logic [47:0] err_q;

  // ram ports
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [31:0]       ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  logic [31:0]       ram_rdata;

  // shared subtractor
  logic [63:0] sub_a;
  logic [63:0] sub_b;
  logic [64:0] sub_diff;
  logic        sub_borrow;

  // shared multiplier
  logic [31:0] mul_x;
  logic [35:0] mul_c;
  logic [17:0] mul_cpart;
  logic [49:0] mul_p;
  logic [63:0] div_d;

  // time bookkeeping on accept
  logic [17:0] time_sum;
  logic [16:0] time_sat;
  logic        time_adv;

  // bin and sum updates
  logic [32:0] bin_add;
  logic [32:0] sum_add;
  logic [27:0] t_prod;
  logic [27:0] t_sum;

  logic item_take;
  logic result_free;

  assign unit_eff  = (unit_len == 16'd0) ? 16'd1 : unit_len;
  assign alpha_eff = (alpha == 20'd0) ? 20'd1 : alpha;

  assign item_stall  = (state != S_IDLE);
  assign item_take   = item_valid && !item_stall;
  assign result_free = !result_valid || !result_stall;

  assign slot_inc = (write_slot == SLOT_LAST) ? '0 : write_slot + SLOT_W'(1);

  assign time_sum = 18'(time_in_unit) + 18'(item.period_ms);
  assign time_sat = time_sum[17] ? SAT17 : time_sum[16:0];
  assign time_adv = (time_sat >= 17'(unit_eff));

  assign bin_add = 33'(ram_rdata) + 33'(held.pulse_count);
  assign sum_add = 33'(window_sum) + 33'(held.pulse_count);

  assign t_prod = 28'(filled_units) * 28'(unit_eff);
  assign t_sum  = t_prod + 28'(time_in_unit);

  // operand selection for the multiplier and divisor
  always_comb begin
    case (op)
      OP_CPM: begin
        mul_x = window_sum;
        mul_c = CPM_SCALE;
        div_d = 64'(t_reg);
      end
      OP_DOSE: begin
        mul_x = window_sum;
        mul_c = DOSE_SCALE;
        div_d = 64'(ta_reg);
      end
      OP_ERR: begin
        mul_x = sq_root;
        mul_c = DOSE_SCALE;
        div_d = 64'({ta_reg, 16'd0});
      end
      default: begin
        mul_x = window_sum;
        mul_c = CPM_SCALE;
        div_d = 64'(t_reg);
      end
    endcase
  end

  assign mul_cpart = (state == S_MHI) ? mul_c[35:18] : mul_c[17:0];
  assign mul_p     = 50'(mul_x) * 50'(mul_cpart);

  // operand selection for the subtractor
  always_comb begin
    case (state)
      S_SQRT: begin
        sub_a = 64'({sq_rem, sq_src[31:30]});
        sub_b = 64'({sq_root, 2'b01});
      end
      S_CHK: begin
        sub_a = 64'(num[67:48]);
        sub_b = div_d;
      end
      S_DIV: begin
        sub_a = {div_rem, num[67]};
        sub_b = div_d;
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_borrow = sub_diff[64];

  // bin ram access
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = write_slot;
    ram_wdata = '0;
    ram_raddr = write_slot;
    case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
      end
      S_ADD: begin
        ram_we    = (held.noise_count == 16'd0);
        ram_wdata = bin_add[32] ? SAT32 : bin_add[31:0];
        ram_raddr = slot_inc;
      end
      S_DROP: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  swdrm_ram #(
    .WIDTH (32),
    .DEPTH (BIN_COUNT)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      unit_len <= UNIT_LEN_RESET;
      alpha    <= ALPHA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_UNIT_LEN: unit_len <= cfg_data[15:0];
        CFG_ALPHA:    alpha    <= cfg_data;
        default:      ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLR;
      op           <= OP_CPM;
      clr_cnt      <= '0;
      write_slot   <= '0;
      filled_units <= '0;
      time_in_unit <= '0;
      window_sum   <= '0;
      result_valid <= 1'b0;
      cnt          <= '0;
    end else begin
      // output register: loaded from done, emptied when taken
      if (state == S_DONE && result_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        // zero every bin once after reset
        S_CLR: begin
          clr_cnt <= clr_cnt + SLOT_W'(1);
          if (clr_cnt == SLOT_LAST) begin
            state <= S_IDLE;
          end
        end
        // take an item, advance the unit timer
        S_IDLE: begin
          if (item_take) begin
            held         <= item;
            advance      <= time_adv;
            time_in_unit <= time_adv ? time_sat - 17'(unit_eff) : time_sat;
            state        <= S_ADD;
          end
        end
        // add pulses of a noise-free item to the current bin and the sum, fetch the next bin
        S_ADD: begin
          if (held.noise_count == 16'd0) begin
            window_sum <= sum_add[32] ? SAT32 : sum_add[31:0];
          end
          if (advance) begin
            write_slot <= slot_inc;
            state      <= S_DROP;
          end else begin
            state <= S_TIME;
          end
        end
        // the bin we move into leaves the window
        S_DROP: begin
          window_sum <= (window_sum > ram_rdata) ? window_sum - ram_rdata : '0;
          if (filled_units != SLOT_LAST) begin
            filled_units <= filled_units + SLOT_W'(1);
          end
          state <= S_TIME;
        end
        // integration time, saturating
        S_TIME: begin
          t_reg <= (t_sum > 28'(SAT26)) ? SAT26 : t_sum[25:0];
          state <= S_TA;
        end
        S_TA: begin
          ta_reg  <= 46'(t_reg) * 46'(alpha_eff);
          sq_src  <= window_sum;
          sq_rem  <= '0;
          sq_root <= '0;
          cnt     <= '0;
          op      <= OP_CPM;
          if (t_reg == 26'd0) begin
            cpm_q  <= '0;
            dose_q <= '0;
            err_q  <= '0;
            state  <= S_DONE;
          end else begin
            state <= S_SQRT;
          end
        end
        // sqrt of sum << 32, two radicand bits a step
        S_SQRT: begin
          sq_src <= {sq_src[29:0], 2'b00};
          if (!sub_borrow) begin
            sq_rem  <= sub_diff[33:0];
            sq_root <= {sq_root[30:0], 1'b1};
          end else begin
            sq_rem  <= sub_a[33:0];
            sq_root <= {sq_root[30:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == SQRT_STEPS - 6'd1) begin
            state <= S_MLO;
          end
        end
        // numerator as two partial products
        S_MLO: begin
          mul_lo <= mul_p;
          state  <= S_MHI;
        end
        S_MHI: begin
          mul_hi <= mul_p;
          state  <= S_MSUM;
        end
        S_MSUM: begin
          num   <= 68'(mul_lo) + {mul_hi, 18'd0};
          state <= S_CHK;
        end
        // quotient of 2^48 or more saturates
        S_CHK: begin
          if (!sub_borrow) begin
            case (op)
              OP_CPM:  cpm_q  <= SAT48;
              OP_DOSE: dose_q <= SAT48;
              default: err_q  <= SAT48;
            endcase
            if (op == OP_ERR) begin
              state <= S_DONE;
            end else begin
              op    <= op_t'(op + 2'd1);
              state <= S_MLO;
            end
          end else begin
            div_rem <= 63'(num[67:48]);
            num     <= {num[47:0], 20'd0};
            quo     <= '0;
            cnt     <= '0;
            state   <= S_DIV;
          end
        end
        // restoring division, one quotient bit a step
        S_DIV: begin
          num     <= {num[66:0], 1'b0};
          div_rem <= sub_borrow ? sub_a[62:0] : sub_diff[62:0];
          quo     <= {quo[46:0], !sub_borrow};
          cnt     <= cnt + 6'd1;
          if (cnt == DIV_STEPS - 6'd1) begin
            case (op)
              OP_CPM:  cpm_q  <= {quo[46:0], !sub_borrow};
              OP_DOSE: dose_q <= {quo[46:0], !sub_borrow};
              default: err_q  <= {quo[46:0], !sub_borrow};
            endcase
            if (op == OP_ERR) begin
              state <= S_DONE;
            end else begin
              op    <= op_t'(op + 2'd1);
              state <= S_MLO;
            end
          end
        end
        // hand the item over once the output register is free
        S_DONE: begin
          if (result_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == S_DONE && result_free) begin
      result.window_count     <= window_sum;
      result.integration_ms   <= t_reg;
      result.cpm_milli        <= cpm_q;
      result.dose_rate_milli  <= dose_q;
      result.dose_error_milli <= err_q;
      result.noise_seen       <= (held.noise_count != 16'd0);
      result.pulses_seen      <= (held.pulse_count != 16'd0);
    end
  end

endmodule
